/* src/hpte_pkg.sv */
// hpte_pkg: types and constants shared by the hashed page table engine
// modules: action and status codes, slot body layout, controller commands.
// no dependencies.
package hpte_pkg;

   localparam int KEY_BITS   = 32;
   localparam int PAGE_BITS  = 20;
   localparam int FRAME_BITS = 20;
   localparam int CFG_BITS   = 13;
   localparam logic [CFG_BITS-1:0] TABLE_SIZE_RESET = 13'd4096;

   localparam logic [2:0] ACT_LOOKUP   = 3'd0;
   localparam logic [2:0] ACT_INSERT   = 3'd1;
   localparam logic [2:0] ACT_REMOVE   = 3'd2;
   localparam logic [2:0] ACT_WRITABLE = 3'd3;
   localparam logic [2:0] ACT_READONLY = 3'd4;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   localparam logic [0:0] REG_TABLE_SIZE = 1'b0;

   typedef struct packed {
      logic [KEY_BITS-1:0]   space;
      logic [PAGE_BITS-1:0]  page;
      logic [FRAME_BITS-1:0] frame;
      logic                  valid;
      logic                  dirty;
   } slot_body_type;

   typedef enum logic [2:0] {
      SEL_CUR, SEL_S, SEL_PREV, SEL_POS, SEL_P, SEL_CLR
   } sel_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_CLEAR, OP_LOAD, OP_HOME, OP_PROBE_EV, OP_FIND_EV,
      OP_WALK_START, OP_WALK_EV, OP_W_LINK, OP_W_NEW, OP_W_DIRTY, OP_W_PREV,
      OP_W_CLEAR, OP_W_MOVE, OP_W_UNLINK, OP_RES_OK, OP_RES_NF, OP_RES_FULL
   } op_type;

   typedef struct packed {
      logic    rd;
      sel_type sel;
      op_type  op;
   } cmd_type;

   typedef struct packed {
      logic [2:0] act;
      logic       div_done;
      logic       r_valid;
      logic       r_match;
      logic       r_linked;
      logic       probe_zero;
      logic       probe_last;
      logic       steps_last;
      logic       steps_full;
      logic       has_prev;
      logic       clr_last;
      logic       rsp_busy;
   } stat_type;

endpackage

/* src/hpte_ram.sv */
// hpte_ram: generic single write port, single read port RAM with a
// registered read. no dependencies.
module hpte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* src/hpte_mod_unit.sv */
// hpte_mod_unit: bit-serial remainder of a 32-bit key by the table size,
// one dividend bit per cycle. uses hpte_pkg.
module hpte_mod_unit #(
   parameter int DW = 13
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [31:0]   dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [DW-2:0] rem
);
   import hpte_pkg::*;

   localparam int CW = $clog2(KEY_BITS);

   logic [DW-1:0]       rem_ff, rem_in;
   logic [KEY_BITS-1:0] q_ff, q_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic [DW:0]         trial;

   always_comb begin
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = done_ff;
      trial   = {rem_ff, q_ff[KEY_BITS-1]};
      if (start) begin
         rem_in  = '0;
         q_in    = dividend;
         cnt_in  = '0;
         run_in  = 1'b1;
         done_in = 1'b0;
      end else if (run_ff) begin
         if (trial >= {1'b0, divisor}) begin
            trial = trial - {1'b0, divisor};
         end
         rem_in = trial[DW-1:0];
         q_in   = {q_ff[KEY_BITS-2:0], 1'b0};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(KEY_BITS-1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff[DW-2:0];

endmodule

/* src/hpte_datapath.sv */
// hpte_datapath: slot store, request and walk registers, home slot
// remainder unit and result register. uses hpte_pkg, hpte_ram, hpte_mod_unit.
module hpte_datapath #(
   parameter int SLOTS = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  hpte_pkg::cmd_type                   cmd,
   output hpte_pkg::stat_type                  stat,
   input  logic [hpte_pkg::CFG_BITS-1:0]       cfg_size,
   input  logic [2:0]                          req_action,
   input  logic [hpte_pkg::KEY_BITS-1:0]       req_space_id,
   input  logic [hpte_pkg::PAGE_BITS-1:0]      req_virtual_page,
   input  logic [hpte_pkg::FRAME_BITS-1:0]     req_alloc_frame,
   input  logic                                req_writable,
   input  logic                                req_load_tlb,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [1:0]                          rsp_status,
   output logic [hpte_pkg::FRAME_BITS-1:0]     rsp_found_frame,
   output logic                                rsp_dirty,
   output logic                                rsp_tlb_fill,
   output logic                                rsp_frame_released
);
   import hpte_pkg::*;

   localparam int IW = $clog2(SLOTS);
   localparam int SW = IW + 1;
   localparam int BW = $bits(slot_body_type);
   localparam int EW = BW + IW + 1;

   // request
   logic [2:0]            act_ff;
   logic [KEY_BITS-1:0]   sp_ff;
   logic [PAGE_BITS-1:0]  vp_ff;
   logic [FRAME_BITS-1:0] nf_ff;
   logic                  wr_ff, lt_ff;

   // walk state
   logic [IW-1:0] home_ff, home_in, cur_ff, cur_in, s_ff, s_in;
   logic [IW-1:0] prev_ff, prev_in, pos_ff, pos_in, p_ff, p_in;
   logic [IW-1:0] probe_ff, probe_in, clr_ff, clr_in, pos_link_ff, pos_link_in;
   logic [SW-1:0] steps_ff, steps_in;
   logic          has_prev_ff, has_prev_in, pos_linked_ff, pos_linked_in;
   slot_body_type pos_body_ff, pos_body_in, end_body_ff, end_body_in;

   // result
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [FRAME_BITS-1:0] rsp_frame_ff, rsp_frame_in;
   logic                  rsp_dirty_ff, rsp_dirty_in;
   logic                  rsp_tlb_ff, rsp_tlb_in;
   logic                  rsp_rel_ff, rsp_rel_in;

   logic [SW-1:0] eff;
   logic [SW-1:0] s_inc;
   logic [IW-1:0] addr;
   logic [EW-1:0] rdata, wdata;
   logic          we;
   slot_body_type r_body, w_body, new_body;
   logic [IW-1:0] r_link;
   logic          r_linked, r_match;
   logic          div_done;
   logic [IW-1:0] div_rem;

   always_comb begin
      if (cfg_size < CFG_BITS'(2)) begin
         eff = SW'(2);
      end else if (32'(cfg_size) > SLOTS) begin
         eff = SW'(SLOTS);
      end else begin
         eff = SW'(cfg_size);
      end
   end

   hpte_mod_unit #(.DW(SW)) u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.op == OP_LOAD),
      .dividend (req_space_id ^ KEY_BITS'(req_virtual_page)),
      .divisor  (eff),
      .done     (div_done),
      .rem      (div_rem)
   );

   always_comb begin
      case (cmd.sel)
         SEL_CUR:  addr = cur_ff;
         SEL_S:    addr = s_ff;
         SEL_PREV: addr = prev_ff;
         SEL_POS:  addr = pos_ff;
         SEL_P:    addr = p_ff;
         SEL_CLR:  addr = clr_ff;
         default:  addr = cur_ff;
      endcase
   end

   hpte_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_slots (
      .clock (clock),
      .we    (we),
      .waddr (addr),
      .wdata (wdata),
      .re    (cmd.rd),
      .raddr (addr),
      .rdata (rdata)
   );

   assign r_body   = slot_body_type'(rdata[BW-1:0]);
   assign r_link   = rdata[BW +: IW];
   assign r_linked = rdata[EW-1];
   assign r_match  = r_body.valid && (r_body.space == sp_ff) && (r_body.page == vp_ff);
   assign s_inc    = {1'b0, s_ff} + SW'(1);

   always_comb begin
      new_body.space = sp_ff;
      new_body.page  = vp_ff;
      new_body.frame = nf_ff;
      new_body.valid = 1'b1;
      new_body.dirty = wr_ff;
      w_body         = r_body;
      we             = 1'b1;
      wdata          = {r_linked, r_link, r_body};
      case (cmd.op)
         OP_CLEAR:    wdata = '0;
         OP_W_LINK:   wdata = {1'b1, s_ff, r_body};
         OP_W_NEW:    wdata = {1'b0, {IW{1'b0}}, new_body};
         OP_W_DIRTY: begin
            w_body.dirty = (act_ff == ACT_WRITABLE);
            wdata        = {r_linked, r_link, w_body};
         end
         OP_W_PREV:   wdata = {pos_linked_ff, pos_link_ff, r_body};
         OP_W_CLEAR:  wdata = {r_linked, r_link, {BW{1'b0}}};
         OP_W_MOVE:   wdata = {r_linked, r_link, end_body_ff};
         OP_W_UNLINK: wdata = {1'b0, r_link, r_body};
         default:     we = 1'b0;
      endcase
   end

   always_comb begin
      home_in       = home_ff;
      cur_in        = cur_ff;
      s_in          = s_ff;
      prev_in       = prev_ff;
      pos_in        = pos_ff;
      p_in          = p_ff;
      probe_in      = probe_ff;
      clr_in        = clr_ff;
      steps_in      = steps_ff;
      has_prev_in   = has_prev_ff;
      pos_link_in   = pos_link_ff;
      pos_linked_in = pos_linked_ff;
      pos_body_in   = pos_body_ff;
      end_body_in   = end_body_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_frame_in  = rsp_frame_ff;
      rsp_dirty_in  = rsp_dirty_ff;
      rsp_tlb_in    = rsp_tlb_ff;
      rsp_rel_in    = rsp_rel_ff;
      case (cmd.op)
         OP_CLEAR: clr_in = clr_ff + IW'(1);
         OP_HOME: begin
            home_in     = div_rem;
            cur_in      = div_rem;
            s_in        = div_rem;
            steps_in    = '0;
            probe_in    = '0;
            has_prev_in = 1'b0;
         end
         OP_PROBE_EV: begin
            if (r_body.valid) begin
               s_in     = (s_inc == eff) ? '0 : s_inc[IW-1:0];
               probe_in = probe_ff + IW'(1);
            end
         end
         OP_FIND_EV: begin
            if (r_match) begin
               pos_in        = cur_ff;
               pos_body_in   = r_body;
               pos_link_in   = r_link;
               pos_linked_in = r_linked;
            end else begin
               prev_in     = cur_ff;
               has_prev_in = 1'b1;
               cur_in      = r_link;
               steps_in    = steps_ff + SW'(1);
            end
         end
         OP_WALK_START: begin
            steps_in = '0;
            p_in     = cur_ff;
            if (act_ff == ACT_INSERT) begin
               cur_in = home_ff;
            end
         end
         OP_WALK_EV: begin
            // last body seen is the chain end
            end_body_in = r_body;
            if (r_linked && (steps_ff != SW'(SLOTS))) begin
               p_in     = cur_ff;
               cur_in   = r_link;
               steps_in = steps_ff + SW'(1);
            end
         end
         OP_RES_OK: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_OK;
            rsp_frame_in  = pos_body_ff.frame;
            rsp_dirty_in  = 1'b0;
            rsp_tlb_in    = 1'b0;
            rsp_rel_in    = 1'b0;
            case (act_ff)
               ACT_INSERT: begin
                  rsp_frame_in = nf_ff;
                  rsp_dirty_in = wr_ff;
                  rsp_tlb_in   = lt_ff;
               end
               ACT_LOOKUP: rsp_dirty_in = pos_body_ff.dirty;
               ACT_REMOVE: rsp_rel_in = 1'b1;
               default: begin
                  rsp_dirty_in = (act_ff == ACT_WRITABLE);
                  rsp_tlb_in   = 1'b1;
               end
            endcase
         end
         OP_RES_NF: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_NOT_FOUND;
            rsp_frame_in  = '0;
            rsp_dirty_in  = 1'b0;
            rsp_tlb_in    = 1'b0;
            rsp_rel_in    = 1'b0;
         end
         OP_RES_FULL: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_FULL;
            rsp_frame_in  = nf_ff;
            rsp_dirty_in  = 1'b0;
            rsp_tlb_in    = 1'b0;
            rsp_rel_in    = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         clr_ff       <= '0;
         steps_ff     <= '0;
         probe_ff     <= '0;
         has_prev_ff  <= 1'b0;
         act_ff       <= ACT_LOOKUP;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         clr_ff       <= clr_in;
         steps_ff     <= steps_in;
         probe_ff     <= probe_in;
         has_prev_ff  <= has_prev_in;
         if (cmd.op == OP_LOAD) begin
            act_ff <= req_action;
         end
      end
      if (cmd.op == OP_LOAD) begin
         sp_ff <= req_space_id;
         vp_ff <= req_virtual_page;
         nf_ff <= req_alloc_frame;
         wr_ff <= req_writable;
         lt_ff <= req_load_tlb;
      end
      home_ff       <= home_in;
      cur_ff        <= cur_in;
      s_ff          <= s_in;
      prev_ff       <= prev_in;
      pos_ff        <= pos_in;
      p_ff          <= p_in;
      pos_link_ff   <= pos_link_in;
      pos_linked_ff <= pos_linked_in;
      pos_body_ff   <= pos_body_in;
      end_body_ff   <= end_body_in;
      rsp_status_ff <= rsp_status_in;
      rsp_frame_ff  <= rsp_frame_in;
      rsp_dirty_ff  <= rsp_dirty_in;
      rsp_tlb_ff    <= rsp_tlb_in;
      rsp_rel_ff    <= rsp_rel_in;
   end

   assign stat.act        = act_ff;
   assign stat.div_done   = div_done;
   assign stat.r_valid    = r_body.valid;
   assign stat.r_match    = r_match;
   assign stat.r_linked   = r_linked;
   assign stat.probe_zero = (probe_ff == '0);
   assign stat.probe_last = ({1'b0, probe_ff} == (eff - SW'(1)));
   assign stat.steps_last = (steps_ff == SW'(SLOTS - 1));
   assign stat.steps_full = (steps_ff == SW'(SLOTS));
   assign stat.has_prev   = has_prev_ff;
   assign stat.clr_last   = (clr_ff == IW'(SLOTS - 1));
   assign stat.rsp_busy   = rsp_valid_ff;

   assign rsp_tvalid         = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found_frame    = rsp_frame_ff;
   assign rsp_dirty          = rsp_dirty_ff;
   assign rsp_tlb_fill       = rsp_tlb_ff;
   assign rsp_frame_released = rsp_rel_ff;

   // the store is read and written in separate cycles
   a_rd_wr_apart: assert property (@(posedge clock) disable iff (reset)
      !(we && cmd.rd))
      else $error("slot store read and written in the same cycle");

   a_steps_bound: assert property (@(posedge clock) disable iff (reset)
      steps_ff <= SW'(SLOTS))
      else $error("chain walk went past the step limit");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(cmd.op) == OP_RES_OK || $past(cmd.op) == OP_RES_NF
                               || $past(cmd.op) == OP_RES_FULL))
      else $error("result raised without a result command");

endmodule

/* src/hpte_ctrl.sv */
// hpte_ctrl: request sequencer for the page table engine; clearing pass,
// hashing, probe, chain walks and read-modify-write steps. uses hpte_pkg.
module hpte_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  hpte_pkg::stat_type stat,
   output hpte_pkg::cmd_type  cmd
);
   import hpte_pkg::*;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_DIV, S_PROBE_RD, S_PROBE_EV, S_NEW_WR, S_WALK_INIT,
      S_WALK_RD, S_WALK_EV, S_LINK_RD, S_LINK_WR, S_FIND_RD, S_FIND_EV,
      S_DIRTY_RD, S_DIRTY_WR, S_PREV_RD, S_PREV_WR, S_CLR_RD, S_CLR_WR,
      S_MOVE_RD, S_MOVE_WR, S_END_RD, S_END_WR, S_UNL_RD, S_UNL_WR, S_RESP
   } state_type;

   state_type state_ff, state_in;
   op_type    res_ff, res_in;

   always_comb begin
      state_in = state_ff;
      res_in   = res_ff;
      cmd.rd   = 1'b0;
      cmd.sel  = SEL_CUR;
      cmd.op   = OP_NONE;
      case (state_ff)
         S_CLEAR: begin
            cmd.sel = SEL_CLR;
            cmd.op  = OP_CLEAR;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = OP_LOAD;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (stat.act > ACT_READONLY) begin
               res_in   = OP_RES_NF;
               state_in = S_RESP;
            end else if (stat.div_done) begin
               cmd.op   = OP_HOME;
               state_in = (stat.act == ACT_INSERT) ? S_PROBE_RD : S_FIND_RD;
            end
         end
         S_PROBE_RD: begin
            cmd.rd   = 1'b1;
            cmd.sel  = SEL_S;
            state_in = S_PROBE_EV;
         end
         S_PROBE_EV: begin
            cmd.op = OP_PROBE_EV;
            if (!stat.r_valid) begin
               // a free home slot starts a chain of its own
               state_in = stat.probe_zero ? S_NEW_WR : S_WALK_INIT;
            end else if (stat.probe_last) begin
               res_in   = OP_RES_FULL;
               state_in = S_RESP;
            end else begin
               state_in = S_PROBE_RD;
            end
         end
         S_NEW_WR: begin
            cmd.sel  = SEL_S;
            cmd.op   = OP_W_NEW;
            res_in   = OP_RES_OK;
            state_in = S_RESP;
         end
         S_WALK_INIT: begin
            cmd.op   = OP_WALK_START;
            state_in = S_WALK_RD;
         end
         S_WALK_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_WALK_EV;
         end
         S_WALK_EV: begin
            cmd.op = OP_WALK_EV;
            if (stat.r_linked && !stat.steps_full) begin
               state_in = S_WALK_RD;
            end else begin
               state_in = (stat.act == ACT_INSERT) ? S_LINK_RD : S_MOVE_RD;
            end
         end
         S_LINK_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_LINK_WR;
         end
         S_LINK_WR: begin
            cmd.op   = OP_W_LINK;
            state_in = S_NEW_WR;
         end
         S_FIND_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_FIND_EV;
         end
         S_FIND_EV: begin
            cmd.op = OP_FIND_EV;
            if (stat.r_match) begin
               case (stat.act)
                  ACT_LOOKUP: begin
                     res_in   = OP_RES_OK;
                     state_in = S_RESP;
                  end
                  ACT_REMOVE: begin
                     if (stat.has_prev) begin
                        state_in = S_PREV_RD;
                     end else if (stat.r_linked) begin
                        state_in = S_WALK_INIT;
                     end else begin
                        state_in = S_CLR_RD;
                     end
                  end
                  default: state_in = S_DIRTY_RD;
               endcase
            end else if (!stat.r_linked || stat.steps_last) begin
               res_in   = OP_RES_NF;
               state_in = S_RESP;
            end else begin
               state_in = S_FIND_RD;
            end
         end
         S_DIRTY_RD: begin
            cmd.rd   = 1'b1;
            cmd.sel  = SEL_POS;
            state_in = S_DIRTY_WR;
         end
         S_DIRTY_WR: begin
            cmd.sel  = SEL_POS;
            cmd.op   = OP_W_DIRTY;
            res_in   = OP_RES_OK;
            state_in = S_RESP;
         end
         S_PREV_RD: begin
            cmd.rd   = 1'b1;
            cmd.sel  = SEL_PREV;
            state_in = S_PREV_WR;
         end
         S_PREV_WR: begin
            cmd.sel  = SEL_PREV;
            cmd.op   = OP_W_PREV;
            state_in = S_CLR_RD;
         end
         S_CLR_RD: begin
            cmd.rd   = 1'b1;
            cmd.sel  = SEL_POS;
            state_in = S_CLR_WR;
         end
         S_CLR_WR: begin
            cmd.sel  = SEL_POS;
            cmd.op   = OP_W_CLEAR;
            res_in   = OP_RES_OK;
            state_in = S_RESP;
         end
         S_MOVE_RD: begin
            cmd.rd   = 1'b1;
            cmd.sel  = SEL_POS;
            state_in = S_MOVE_WR;
         end
         S_MOVE_WR: begin
            cmd.sel  = SEL_POS;
            cmd.op   = OP_W_MOVE;
            state_in = S_END_RD;
         end
         S_END_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_END_WR;
         end
         S_END_WR: begin
            cmd.op   = OP_W_CLEAR;
            state_in = S_UNL_RD;
         end
         S_UNL_RD: begin
            cmd.rd   = 1'b1;
            cmd.sel  = SEL_P;
            state_in = S_UNL_WR;
         end
         S_UNL_WR: begin
            cmd.sel  = SEL_P;
            cmd.op   = OP_W_UNLINK;
            res_in   = OP_RES_OK;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!stat.rsp_busy) begin
               cmd.op   = res_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         res_ff   <= OP_RES_NF;
      end else begin
         state_ff <= state_in;
         res_ff   <= res_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !stat.rsp_busy)
      else $error("result pending during the clearing pass");

   a_div_restart: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_LOAD) |=> !stat.div_done)
      else $error("remainder unit reported done right after a start");

   a_resp_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP) |-> (res_ff == OP_RES_OK || res_ff == OP_RES_NF
                                || res_ff == OP_RES_FULL))
      else $error("pending result kind is not a result command");

endmodule

/* src/hashed_page_table_engine.sv */
// hashed_page_table_engine: top level; stream ports, configuration register
// and the controller/datapath pair. uses hpte_pkg, hpte_ctrl, hpte_datapath.
//
//   channel | direction | handshake                  | content
//   req     | in        | req_tvalid / req_tready    | one page table request
//   rsp     | out       | rsp_tvalid / rsp_tready    | one result per request
//   csr     | in        | psel, penable, pwrite      | table_size at address 0
//
// after acceptance a request goes through the bit-serial home slot remainder,
// then a read and an evaluation per probed slot or chain step, a chain walk
// start, a read and a write per slot update (only a write for a fresh entry)
// and a load of the output register. after reset a clearing pass runs with
// req_tready low. a result waits in the output register while the next
// request is accepted and worked.
module hashed_page_table_engine #(
   parameter int SLOTS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // space_id[31:0], virtual_page[51:32], alloc_frame[71:52], writable[72],
   // load_tlb[73], zero fill[79:74]
   input  logic [79:0] req_tdata,
   // action[2:0]
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // found_frame[19:0], dirty[20], tlb_fill[21], frame_released[22], zero[23]
   output logic [23:0] rsp_tdata,
   // status[1:0]
   output logic [1:0]  rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import hpte_pkg::*;

   logic [CFG_BITS-1:0]   table_size_ff, table_size_in;
   cmd_type               cmd;
   stat_type              stat;
   logic [FRAME_BITS-1:0] found_frame;
   logic                  dirty, tlb_fill, frame_released;

   always_comb begin
      table_size_in = table_size_ff;
      if (csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == REG_TABLE_SIZE)) begin
         table_size_in = csr_pwdata[CFG_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= TABLE_SIZE_RESET;
      end else begin
         table_size_ff <= table_size_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_TABLE_SIZE) ? 32'(table_size_ff) : 32'd0;

   hpte_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   hpte_datapath #(.SLOTS(SLOTS)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .cfg_size           (table_size_ff),
      .req_action         (req_tuser),
      .req_space_id       (req_tdata[31:0]),
      .req_virtual_page   (req_tdata[51:32]),
      .req_alloc_frame    (req_tdata[71:52]),
      .req_writable       (req_tdata[72]),
      .req_load_tlb       (req_tdata[73]),
      .rsp_tready         (rsp_tready),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_status         (rsp_tuser),
      .rsp_found_frame    (found_frame),
      .rsp_dirty          (dirty),
      .rsp_tlb_fill       (tlb_fill),
      .rsp_frame_released (frame_released)
   );

   assign rsp_tdata = {1'b0, frame_released, tlb_fill, dirty, found_frame};

endmodule

/* tb/sv/tb_hashed_page_table_engine.sv */
// tb_hashed_page_table_engine: self-checking testbench for the hashed page table
// engine; a built-in table predictor, random idling on both streams, csr writes.
// depends on hpte_pkg and hashed_page_table_engine.
`timescale 1ns / 100ps

module tb_hashed_page_table_engine;
   import hpte_pkg::*;

   localparam int SLOTS = 4096;
   localparam int WATCHDOG_LIMIT = 200000;
   localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
   localparam logic [2:0] ACT_SPARE_LAST = 3'd7;
   localparam logic [2:0] ADDR_TABLE_SIZE = 3'(REG_TABLE_SIZE) << 2;

   typedef struct {
      logic [1:0]  status;
      logic [19:0] frame;
      logic        dirty;
      logic        tlb;
      logic        released;
   } page_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   hashed_page_table_engine #(.SLOTS(SLOTS)) dut (.*);

   // predicted table contents
   logic [31:0]   tbl_space [SLOTS];
   logic [19:0]   tbl_page  [SLOTS];
   logic [19:0]   tbl_frame [SLOTS];
   bit            tbl_valid [SLOTS];
   bit            tbl_dirty [SLOTS];
   int unsigned   tbl_link  [SLOTS];
   bit            tbl_linked[SLOTS];
   logic [12:0]   table_size_reg = TABLE_SIZE_RESET;

   page_result_type pending_results[$];
   int            errors = 0;
   int            requests_sent = 0;
   int            status_count[4] = '{0, 0, 0, 0};
   int            idle_cycles = 0;
   bit            quiet_phase = 1'b0;
   int            stall_left = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic bit [31:0] size_in_use();
      bit [31:0] s = 32'(table_size_reg);
      if (s < 2) s = 2;
      if (s > SLOTS) s = SLOTS;
      return s;
   endfunction

   function automatic bit [31:0] home_slot(logic [31:0] sp, logic [19:0] vp);
      return (sp ^ {12'd0, vp}) % size_in_use();
   endfunction

   function automatic void wipe_slot(int unsigned s);
      tbl_space[s] = '0; tbl_page[s] = '0; tbl_frame[s] = '0;
      tbl_valid[s] = 0;  tbl_dirty[s] = 0;
   endfunction

   function automatic bit find_page(logic [31:0] sp, logic [19:0] vp, output int unsigned pos,
                                    output int unsigned prev, output bit has_prev);
      int unsigned cur = home_slot(sp, vp);
      has_prev = 0; prev = 0; pos = 0;
      for (int n = 0; n < SLOTS; n++) begin
         if (tbl_valid[cur] && tbl_space[cur] == sp && tbl_page[cur] == vp) begin
            pos = cur;
            return 1;
         end
         prev = cur;
         has_prev = 1;
         if (!tbl_linked[cur]) return 0;
         cur = tbl_link[cur] % SLOTS;
      end
      return 0;
   endfunction

   function automatic page_result_type page_table_update(logic [2:0] act, logic [31:0] sp,
         logic [19:0] vp, logic [19:0] nf, logic wr, logic lt);
      page_result_type r = '{ST_NOT_FOUND, 20'd0, 1'b0, 1'b0, 1'b0};
      int unsigned pos, prev, s, t, tail, before_tail;
      int unsigned size = size_in_use();
      int unsigned home = home_slot(sp, vp);
      bit has_prev, got;
      if (act == ACT_INSERT) begin
         got = 0; s = 0;
         for (int unsigned i = 0; i < size; i++) begin
            s = (home + i) % size;
            if (!tbl_valid[s]) begin got = 1; break; end
         end
         if (!got) begin
            r.status = ST_FULL; r.frame = nf; r.released = 1;
         end else begin
            if (tbl_valid[home]) begin
               t = home;
               for (int n = 0; n < SLOTS && tbl_linked[t]; n++) t = tbl_link[t] % SLOTS;
               tbl_link[t] = s;
               tbl_linked[t] = 1;
            end
            tbl_space[s] = sp; tbl_page[s] = vp; tbl_frame[s] = nf;
            tbl_valid[s] = 1; tbl_dirty[s] = wr; tbl_link[s] = 0; tbl_linked[s] = 0;
            r = '{ST_OK, nf, wr, lt, 1'b0};
         end
      end else if (act inside {ACT_LOOKUP, ACT_REMOVE, ACT_WRITABLE, ACT_READONLY}) begin
         if (find_page(sp, vp, pos, prev, has_prev)) begin
            r.status = ST_OK;
            r.frame = tbl_frame[pos];
            if (act == ACT_LOOKUP) begin
               r.dirty = tbl_dirty[pos];
            end else if (act != ACT_REMOVE) begin
               tbl_dirty[pos] = (act == ACT_WRITABLE);
               r.dirty = tbl_dirty[pos];
               r.tlb = 1;
            end else begin
               r.released = 1;
               if (has_prev) begin
                  tbl_link[prev] = tbl_link[pos];
                  tbl_linked[prev] = tbl_linked[pos];
                  wipe_slot(pos);
               end else if (tbl_linked[pos]) begin
                  // chain head goes: pull the tail entry into the home slot
                  tail = pos; before_tail = pos;
                  for (int n = 0; n < SLOTS && tbl_linked[tail]; n++) begin
                     before_tail = tail;
                     tail = tbl_link[tail] % SLOTS;
                  end
                  tbl_space[pos] = tbl_space[tail]; tbl_page[pos] = tbl_page[tail];
                  tbl_frame[pos] = tbl_frame[tail]; tbl_valid[pos] = tbl_valid[tail];
                  tbl_dirty[pos] = tbl_dirty[tail];
                  wipe_slot(tail);
                  tbl_linked[before_tail] = 0;
               end else begin
                  wipe_slot(pos);
               end
            end
         end
      end
      return r;
   endfunction

   function automatic int pick_gap();
      int r = $urandom_range(0, 99);
      if (quiet_phase || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      errors++;
      $display("mismatch on %s: got %0h, expected %0h (request %0d)",
               what, got, want, requests_sent);
   endtask

   task automatic send_request(logic [2:0] act, logic [31:0] sp, logic [19:0] vp,
                               logic [19:0] nf, logic wr, logic lt);
      int gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {6'd0, lt, wr, nf, vp, sp};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(page_table_update(act, sp, vp, nf, wr, lt));
      requests_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_table_size(logic [31:0] value);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_TABLE_SIZE; csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      table_size_reg = value[12:0];
      csr_pwrite <= 1'b0; csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[12:0] !== table_size_reg)
         report_mismatch("table_size readback", csr_prdata[12:0], table_size_reg);
      csr_psel <= 1'b0; csr_penable <= 1'b0;
   endtask

   // result checker
   always @(posedge clock) begin
      page_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing outstanding, status", rsp_tuser, 0);
         end else begin
            want = pending_results.pop_front();
            status_count[want.status]++;
            if (rsp_tuser !== want.status) report_mismatch("status", rsp_tuser, want.status);
            if (rsp_tdata[19:0] !== want.frame)
               report_mismatch("found_frame", rsp_tdata[19:0], want.frame);
            if (rsp_tdata[20] !== want.dirty) report_mismatch("dirty", rsp_tdata[20], want.dirty);
            if (rsp_tdata[21] !== want.tlb)
               report_mismatch("tlb_fill", rsp_tdata[21], want.tlb);
            if (rsp_tdata[22] !== want.released)
               report_mismatch("frame_released", rsp_tdata[22], want.released);
         end
      end
   end

   // receiver back-pressure, mostly short stalls and a few long ones
   always @(posedge clock) begin
      int r;
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         r = $urandom_range(0, 99);
         if (!quiet_phase && r < 10)
            stall_left <= (r < 8) ? $urandom_range(1, 4) : $urandom_range(20, 120);
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("FAIL hashed_page_table_engine");
         $finish;
      end
   end

   task automatic test_basic_actions();
      send_request(ACT_LOOKUP, 32'hFFFF_FFFF, 20'hFFFFF, 20'h0, 1'b0, 1'b0);
      send_request(ACT_INSERT, 32'hFFFF_FFFF, 20'hFFFFF, 20'hFFFFF, 1'b1, 1'b1);
      send_request(ACT_INSERT, 32'h0, 20'h0, 20'h0, 1'b0, 1'b0);
      send_request(ACT_LOOKUP, 32'hFFFF_FFFF, 20'hFFFFF, 20'h0, 1'b0, 1'b0);
      send_request(ACT_READONLY, 32'hFFFF_FFFF, 20'hFFFFF, 20'h0, 1'b0, 1'b0);
      send_request(ACT_WRITABLE, 32'h0, 20'h0, 20'h0, 1'b0, 1'b0);
      send_request(ACT_LOOKUP, 32'h0, 20'h0, 20'h0, 1'b0, 1'b0);
      for (logic [3:0] a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++)
         send_request(a[2:0], 32'h0, 20'h0, 20'hABCDE, 1'b1, 1'b1);
      send_request(ACT_REMOVE, 32'hFFFF_FFFF, 20'hFFFFF, 20'h0, 1'b0, 1'b0);
      send_request(ACT_REMOVE, 32'hFFFF_FFFF, 20'hFFFFF, 20'h0, 1'b0, 1'b0);
      send_request(ACT_WRITABLE, 32'h1234_5678, 20'h9ABCD, 20'h0, 1'b0, 1'b0);
      wait_idle();
   endtask

   task automatic test_chain_and_full();
      write_table_size(32'd4);
      // three keys sharing home slot 0, then drop the chain head
      send_request(ACT_INSERT, 32'h0, 20'd0, 20'h11111, 1'b0, 1'b1);
      send_request(ACT_INSERT, 32'h0, 20'd4, 20'h22222, 1'b1, 1'b0);
      send_request(ACT_INSERT, 32'h0, 20'd8, 20'h33333, 1'b1, 1'b1);
      send_request(ACT_REMOVE, 32'h0, 20'd0, 20'h0, 1'b0, 1'b0);
      send_request(ACT_LOOKUP, 32'h0, 20'd8, 20'h0, 1'b0, 1'b0);
      send_request(ACT_REMOVE, 32'h0, 20'd4, 20'h0, 1'b0, 1'b0);
      send_request(ACT_LOOKUP, 32'h0, 20'd8, 20'h0, 1'b0, 1'b0);
      send_request(ACT_INSERT, 32'h0, 20'd1, 20'h44444, 1'b0, 1'b0);
      send_request(ACT_INSERT, 32'h0, 20'd12, 20'h55555, 1'b0, 1'b0);
      send_request(ACT_INSERT, 32'h0, 20'd16, 20'h66666, 1'b0, 1'b0);
      send_request(ACT_INSERT, 32'h0, 20'd20, 20'h77777, 1'b1, 1'b1);
      send_request(ACT_LOOKUP, 32'h0, 20'd16, 20'h0, 1'b0, 1'b0);
      wait_idle();
   endtask

   task automatic test_size_limits();
      logic [31:0] sizes[5] = '{32'd0, 32'd1, 32'h1FFF, 32'hFFFF_E003, 32'd2};
      foreach (sizes[i]) begin
         write_table_size(sizes[i]);
         repeat (3) send_request(ACT_INSERT, $urandom, 20'($urandom), 20'($urandom),
                                 1'($urandom), 1'($urandom));
         send_request(ACT_LOOKUP, $urandom, 20'($urandom), 20'h0, 1'b0, 1'b0);
         wait_idle();
      end
   endtask

   task automatic test_random_traffic(int phases, int per_phase);
      logic [31:0] key_space[10];
      logic [19:0] key_page[10];
      logic [2:0]  act;
      logic [31:0] sp;
      logic [19:0] vp;
      int r, k;
      for (int ph = 0; ph < phases; ph++) begin
         r = $urandom_range(0, 9);
         write_table_size(r < 6 ? $urandom_range(2, 16) : r < 8 ? $urandom_range(17, 300) :
                          r < 9 ? 32'd4096 : $urandom_range(0, 8191));
         quiet_phase = (ph % 4 == 3);
         foreach (key_space[i]) begin
            key_space[i] = (ph % 2) ? $urandom : $urandom_range(0, 7);
            key_page[i] = (ph % 2) ? 20'($urandom) : 20'($urandom_range(0, 40));
         end
         for (int n = 0; n < per_phase; n++) begin
            r = $urandom_range(0, 99);
            act = r < 35 ? ACT_INSERT : r < 55 ? ACT_LOOKUP : r < 75 ? ACT_REMOVE :
                  r < 85 ? ACT_WRITABLE : r < 95 ? ACT_READONLY :
                  3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
            k = $urandom_range(0, 9);
            sp = key_space[k];
            vp = key_page[k];
            if ($urandom_range(0, 99) < 12) begin
               sp = $urandom;
               vp = 20'($urandom);
            end
            send_request(act, sp, vp, 20'($urandom), 1'($urandom), 1'($urandom));
         end
         wait_idle();
      end
      quiet_phase = 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_basic_actions();
      test_chain_and_full();
      test_size_limits();
      test_random_traffic(12, 150);
      wait_idle();
      $display("%0d requests: %0d ok, %0d not found, %0d table full; sizes 0 to 8191 used",
               requests_sent, status_count[ST_OK], status_count[ST_NOT_FOUND],
               status_count[ST_FULL]);
      if (errors == 0) begin
         $display("PASS hashed_page_table_engine");
      end else begin
         $display("%0d mismatches", errors);
         $display("FAIL hashed_page_table_engine");
      end
      $finish;
   end

endmodule
